// ===== hdl/lsap_pkg.sv =====
// Package: shared types, constants and state codes for the shelf atlas packer.
package lsap_pkg;

  localparam int MAX_LAYERS_DEF  = 16;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int COORD_BITS_DEF  = 14;

  localparam int KEY_W   = 32;
  localparam int FIELD_W = 14;
  localparam int LCNT_W  = 5;
  localparam int LAYER_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 2'd2;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_PLACED = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAYER,
    S_SCAN,
    S_WAIT,
    S_PLACE,
    S_DONE
  } fsm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, reset layer to 1
    logic scan_start; // restart entry scan
    logic scan_step;  // advance entry scan
    logic next_layer; // advance layer
    logic place;      // commit placement step on current layer
    logic finish;     // load result register with fail code
    logic hit_out;    // load result register from matched entry
  } lsap_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic layers_done; // current layer beyond the last one in use
    logic scan_done;   // entry scan pointer at entry count
    logic hit;         // match of the registered previous read
    logic hit_vld;     // read data valid this cycle
    logic full;        // table full
    logic fits;        // placement would succeed
    logic out_busy;    // result register still occupied
  } lsap_sts_t;

endpackage

// ===== hdl/lsap_if.sv =====
// Interfaces: valid/ready channels for requests, results and configuration.
interface lsap_req_if;
  import lsap_pkg::*;
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   image_key;
  logic [FIELD_W-1:0] image_width;
  logic [FIELD_W-1:0] image_height;
  logic               has_pixels;
  modport source (output valid, image_key, image_width, image_height, has_pixels,
                  input ready);
  modport sink (input valid, image_key, image_width, image_height, has_pixels,
                output ready);
endinterface

interface lsap_res_if;
  import lsap_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [LAYER_W-1:0] layer;
  logic [FIELD_W-1:0] pos_x;
  logic [FIELD_W-1:0] pos_y;
  logic               upload;
  modport source (output valid, status, layer, pos_x, pos_y, upload, input ready);
  modport sink (input valid, status, layer, pos_x, pos_y, upload, output ready);
endinterface

interface lsap_cfg_if;
  import lsap_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/lsap_ctrl.sv =====
// Controller: sequences layer walk, entry scan, placement and result hand-off.
module lsap_ctrl
  import lsap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  lsap_sts_t sts,
  output logic      busy,
  output lsap_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_LAYER;
        end
      end
      S_LAYER: begin
        if (sts.layers_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // one read issued per cycle; match result arrives in the next cycle
        if (sts.hit_vld && sts.hit) begin
          state_nxt = S_WAIT;
        end else if (sts.scan_done) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WAIT: begin
        if (!sts.out_busy) begin
          cmd.hit_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_PLACE: begin
        if (sts.full) begin
          cmd.next_layer = 1'b1;
          state_nxt      = S_LAYER;
        end else if (sts.fits) begin
          if (!sts.out_busy) begin
            cmd.place = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.place      = 1'b1;
          cmd.next_layer = 1'b1;
          state_nxt      = S_LAYER;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/lsap_dp.sv =====
// Datapath: pens, entry table memory, scan, placement and result register.
module lsap_dp
  import lsap_pkg::*;
#(
  parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lsap_req_if.sink           req,
  lsap_res_if.source         res,
  lsap_cfg_if.sink           cfg,
  input  logic               busy,
  input  lsap_cmd_t          cmd,
  output lsap_sts_t          sts
);

  localparam int LW = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
  localparam int LIW = $clog2(MAX_LAYERS + 1);
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = FIELD_W + 2;
  localparam logic [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);

  // Configuration registers
  logic [FIELD_W-1:0] aw_r, ah_r;
  logic [LCNT_W-1:0]  lc_r;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= FIELD_W'(1024);
      ah_r <= FIELD_W'(1024);
      lc_r <= LCNT_W'(16);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ATLAS_WIDTH:  aw_r <= cfg.data;
        REG_ATLAS_HEIGHT: ah_r <= cfg.data;
        REG_LAYER_COUNT:  lc_r <= cfg.data[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture
  logic [KEY_W-1:0]   key_r;
  logic [FIELD_W-1:0] w_r, h_r;
  logic               pix_r;
  logic [LIW-1:0]     lay_r;
  logic               full_r;
  logic [CW-1:0]      cnt_r;

  assign req.ready = !busy;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= req.image_key;
      w_r    <= req.image_width;
      h_r    <= req.image_height;
      pix_r  <= req.has_pixels;
      full_r <= (cnt_r == CW'(MAX_ENTRIES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lay_r <= '0;
    end else if (cmd.load) begin
      lay_r <= LIW'(1);
    end else if (cmd.next_layer) begin
      lay_r <= lay_r + LIW'(1);
    end
  end

  // Clamp layer count to the layer store depth
  logic [LIW:0] nl;
  always_comb begin
    if ({{(LIW+1 > LCNT_W ? LIW+1-LCNT_W : 0){1'b0}}, lc_r} > (LIW+1 > LCNT_W ? LIW+1 : LCNT_W)'(MAX_LAYERS))
      nl = (LIW+1)'(MAX_LAYERS);
    else
      nl = (LIW+1)'(lc_r);
  end
  assign sts.layers_done = ({1'b0, lay_r} >= nl);
  assign sts.full        = full_r;

  // Per-layer pens
  logic [FIELD_W-1:0] pen_x_r [MAX_LAYERS];
  logic [FIELD_W-1:0] pen_y_r [MAX_LAYERS];
  logic [FIELD_W-1:0] rh_r    [MAX_LAYERS];
  logic [LW-1:0] li;
  assign li = lay_r[LW-1:0];

  logic [SW-1:0] px, py, rh, wrap_y, cur_x, cur_y, nx;
  logic          wrap;
  always_comb begin
    px     = SW'(pen_x_r[li]);
    py     = SW'(pen_y_r[li]);
    rh     = SW'(rh_r[li]);
    wrap   = (px + SW'(w_r)) > SW'(aw_r);
    wrap_y = (py + rh > CMAX) ? CMAX : py + rh;
    cur_x  = wrap ? '0 : px;
    cur_y  = wrap ? wrap_y : py;
    nx     = (cur_x + SW'(w_r) + SW'(1) > CMAX) ? CMAX : cur_x + SW'(w_r) + SW'(1);
  end
  assign sts.fits = !((cur_y + SW'(h_r)) > SW'(ah_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
        pen_x_r[i] <= '0;
        pen_y_r[i] <= '0;
        rh_r[i]    <= '0;
      end
    end else if (cmd.place) begin
      if (sts.fits) begin
        pen_x_r[li] <= FIELD_W'(nx);
        pen_y_r[li] <= FIELD_W'(cur_y);
        if (SW'(h_r) > (wrap ? SW'(0) : rh))
          rh_r[li] <= FIELD_W'((SW'(h_r) > CMAX) ? CMAX : SW'(h_r));
        else if (wrap)
          rh_r[li] <= '0;
      end else if (wrap) begin
        pen_x_r[li] <= '0;
        pen_y_r[li] <= FIELD_W'(wrap_y);
        rh_r[li]    <= '0;
      end
    end
  end

  // Entry table memory, one registered read port
  localparam int MW = KEY_W + LAYER_W + 2 * FIELD_W;
  logic [MW-1:0] mem [MAX_ENTRIES];
  logic [MW-1:0] rd_r;
  logic [CW-1:0] sp_r;
  logic          rv_r;
  logic          wr_en;

  assign wr_en = cmd.place && sts.fits;
  assign sts.scan_done = (sp_r >= cnt_r);

  // Read only while stepping so a matched entry is held for the result
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[EW-1:0]] <= {key_r, LAYER_W'(lay_r), FIELD_W'(cur_x), FIELD_W'(cur_y)};
    end
    if (cmd.scan_step) begin
      rd_r <= mem[sp_r[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      rv_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        sp_r <= '0;
        rv_r <= 1'b0;
      end else if (cmd.scan_step) begin
        sp_r <= sp_r + CW'(1);
        rv_r <= 1'b1;
      end else begin
        rv_r <= 1'b0;
      end
      if (wr_en) cnt_r <= cnt_r + CW'(1);
    end
  end

  assign sts.hit_vld = rv_r;
  assign sts.hit     = (rd_r[MW-1 -: KEY_W] == key_r) &&
                       (rd_r[2*FIELD_W +: LAYER_W] == LAYER_W'(lay_r));

  // Result register
  logic               ov_r;
  logic [1:0]         st_r;
  logic [LAYER_W-1:0] ol_r;
  logic [FIELD_W-1:0] ox_r, oy_r;
  logic               up_r;

  assign sts.out_busy = ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.hit_out || wr_en || cmd.finish) begin
      ov_r <= 1'b1;
    end else if (res.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_out) begin
      st_r <= ST_FOUND;
      ol_r <= LAYER_W'(lay_r);
      ox_r <= rd_r[FIELD_W +: FIELD_W];
      oy_r <= rd_r[0 +: FIELD_W];
      up_r <= 1'b0;
    end else if (wr_en) begin
      st_r <= ST_PLACED;
      ol_r <= LAYER_W'(lay_r);
      ox_r <= FIELD_W'(cur_x);
      oy_r <= FIELD_W'(cur_y);
      up_r <= pix_r;
    end else if (cmd.finish) begin
      st_r <= full_r ? ST_FULL : ST_NOROOM;
      ol_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
      up_r <= 1'b0;
    end
  end

  assign res.valid  = ov_r;
  assign res.status = st_r;
  assign res.layer  = ol_r;
  assign res.pos_x  = ox_r;
  assign res.pos_y  = oy_r;
  assign res.upload = up_r;

endmodule

// ===== hdl/layered_shelf_atlas_packer_unit.sv =====
// Scan: per layer, the entry table is read serially, one table read per cycle.
// Throughput: one item at a time; each item waits on the serial entry-table scan per layer.
// A finished result waits in the output register while the next item is taken.
// Reset: rst_n synchronous active low; clears pens, entry count and handshake state.
// The entry table is not cleared; only entries below the entry count are read.
// Configuration resets to width 1024, height 1024, layer count 16.
module layered_shelf_atlas_packer_unit
  import lsap_pkg::*;
#(
  parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lsap_req_if.sink   in_req,
  lsap_res_if.source out_res,
  lsap_cfg_if.sink   cfg_wr
);

  lsap_cmd_t cmd;
  lsap_sts_t sts;
  logic      busy;

  lsap_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_req.valid && in_req.ready),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  lsap_dp #(
    .MAX_LAYERS  (MAX_LAYERS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .res   (out_res),
    .cfg   (cfg_wr),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // A result stays offered until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid)
    else $error("result dropped before taken");

  // No request is taken while one is in progress
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_req.ready)
    else $error("request taken while busy");

  // The result register is never overwritten by a hit or a fail code while occupied
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |-> !(cmd.hit_out || cmd.finish))
    else $error("result overwritten");

endmodule
